FILE: hw/rtl/ctc_greedy_decoder_macros.svh
// ----------------------------------------------------------------------------
// ctc greedy decoder assertion macros
// Concurrent assertion wrappers used by the decoder controller; they compile
// to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef CTC_GREEDY_DECODER_MACROS_SVH
`define CTC_GREEDY_DECODER_MACROS_SVH

`ifndef ASSERT_OFF
// clocked assertion, off while reset is held
`define CTC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ctc greedy decoder assertion failed");
// clocked assertion, checked during reset too
`define CTC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ctc greedy decoder assertion failed");
`else
`define CTC_ASSERT(label, clk, rst_n, prop)
`define CTC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hw/rtl/ctc_pkg.sv
// ----------------------------------------------------------------------------
// ctc greedy decoder package
// Controller states, command and status bundles and fixed constants.
// ----------------------------------------------------------------------------
package ctc_pkg;

    // width and reset value of the char_count register
    localparam int CHARS_W = 13;
    localparam logic [CHARS_W-1:0] CHARS_RESET = 13'd37;

    // result kind codes
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_CHAR,
        S_DSTART,
        S_DIV,
        S_END
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic acc;        // input transfer this cycle
        logic row;        // row decision and running sum update
        logic load_char;  // load character result into output register
        logic div_start;  // start average division
        logic load_end;   // load sequence end result, clear sequence state
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit_now;   // row winner is to be emitted
        logic end_seq;    // current row closes the sequence
        logic out_free;   // output register can take a result
        logic div_busy;   // divider running
    } t_status;

endpackage

FILE: hw/rtl/ctc_divider.sv
// ----------------------------------------------------------------------------
// ctc divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ctc_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_shift;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    // trial subtraction of one step
    always_comb begin
        w_shift = {r_rem, r_quo[NUM_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/ctc_datapath.sv
// ----------------------------------------------------------------------------
// ctc datapath
// Running argmax, row decision, confidence sum, average and output register.
// ----------------------------------------------------------------------------
module ctc_datapath #(
    parameter int MAX_CLASSES = 4096,
    parameter int MAX_STEPS   = 1024,
    parameter int SCORE_WIDTH = 16,
    parameter int CLASS_W     = 12,
    parameter int CNT_W       = 11,
    parameter int SUM_W       = 26,
    parameter int IN_W        = 16,
    parameter int OUT_W       = 40
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ctc_pkg::t_cmd                  i_cmd,
    output ctc_pkg::t_status               o_status,
    // input payload
    input  logic [IN_W-1:0]                i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    input  logic                           i_s_axis_tuser,
    // configuration
    input  logic                           i_cfg_valid,
    input  logic [ctc_pkg::CHARS_W-1:0]    i_cfg_data,
    // result side
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [OUT_W-1:0]               o_m_axis_tdata,
    output logic                           o_m_axis_tlast,
    output logic                           o_m_axis_tuser
);

    localparam int POS_W = $clog2(MAX_CLASSES + 1);
    localparam int CMP_W = (CLASS_W > ctc_pkg::CHARS_W) ? CLASS_W : ctc_pkg::CHARS_W;
    localparam int PAD_W = OUT_W - CLASS_W - SCORE_WIDTH - CNT_W;

    logic [ctc_pkg::CHARS_W-1:0]  r_char_count;
    logic [POS_W-1:0]             r_pos;
    logic signed [SCORE_WIDTH-1:0] r_best_score;
    logic [CLASS_W-1:0]           r_best_class;
    logic [CLASS_W-1:0]           r_prev_class;
    logic                         r_prev_valid;
    logic signed [SUM_W-1:0]      r_sum;
    logic [CNT_W-1:0]             r_count;
    logic                         r_end_seq;
    logic                         r_neg;
    logic                         r_zero;

    logic                         r_out_valid;
    logic                         r_out_kind;
    logic [CLASS_W-1:0]           r_out_class;
    logic [SCORE_WIDTH-1:0]       r_out_conf;
    logic [CNT_W-1:0]             r_out_total;
    logic                         r_out_last;

    logic signed [SCORE_WIDTH-1:0] w_score;
    logic                         w_in_range;
    logic                         w_repeat;
    logic                         w_emit;
    logic                         w_out_free;
    logic [SUM_W-1:0]             w_mag;
    logic                         w_div_busy;
    logic [SUM_W-1:0]             w_quo;
    logic [SCORE_WIDTH-1:0]       w_avg;

    assign w_score    = i_s_axis_tdata[SCORE_WIDTH-1:0];
    assign w_in_range = (r_pos < POS_W'(MAX_CLASSES));

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= ctc_pkg::CHARS_RESET;
        end else if (i_cfg_valid) begin
            r_char_count <= i_cfg_data;
        end
    end

    // row decision on the finished maximum
    always_comb begin
        w_repeat = r_prev_valid && (r_best_class == r_prev_class);
        w_emit   = (r_best_class != '0) && !w_repeat
                   && (CMP_W'(r_best_class) < CMP_W'(r_char_count));
    end

    // running argmax and row position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_best_score <= '0;
            r_best_class <= '0;
            r_end_seq    <= 1'b0;
        end else if (i_cmd.acc) begin
            if (r_pos == '0) begin
                r_best_score <= w_score;
                r_best_class <= '0;
            end else if (w_in_range && (w_score > r_best_score)) begin
                r_best_score <= w_score;
                r_best_class <= r_pos[CLASS_W-1:0];
            end
            if (w_in_range) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_s_axis_tlast) begin
                r_end_seq <= i_s_axis_tuser;
            end
        end else if (i_cmd.row) begin
            r_pos <= '0;
        end
    end

    // previous winner, confidence sum and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
        end else if (i_cmd.row) begin
            r_prev_class <= r_best_class;
            r_prev_valid <= 1'b1;
            if (w_emit && (r_count < CNT_W'(MAX_STEPS))) begin
                r_sum   <= r_sum + SUM_W'(r_best_score);
                r_count <= r_count + 1'b1;
            end
        end else if (i_cmd.load_end) begin
            r_prev_class <= '0;
            r_prev_valid <= 1'b0;
            r_sum        <= '0;
            r_count      <= '0;
        end
    end

    // average: magnitude division, sign applied afterwards
    assign w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg  <= r_sum[SUM_W-1];
            r_zero <= (r_count == '0);
        end
    end

    ctc_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_count),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        if (r_zero) begin
            w_avg = '0;
        end else if (r_neg) begin
            w_avg = -w_quo[SCORE_WIDTH-1:0];
        end else begin
            w_avg = w_quo[SCORE_WIDTH-1:0];
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_char || i_cmd.load_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_char) begin
            r_out_kind  <= ctc_pkg::KIND_CHAR;
            r_out_class <= r_best_class;
            r_out_conf  <= r_best_score;
            r_out_total <= '0;
            r_out_last  <= 1'b0;
        end else if (i_cmd.load_end) begin
            r_out_kind  <= ctc_pkg::KIND_END;
            r_out_class <= '0;
            r_out_conf  <= w_avg;
            r_out_total <= r_count;
            r_out_last  <= 1'b1;
        end
    end

    // status to controller
    always_comb begin
        o_status.emit_now = w_emit;
        o_status.end_seq  = r_end_seq;
        o_status.out_free = w_out_free;
        o_status.div_busy = w_div_busy;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_total, r_out_conf, r_out_class};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_kind;

endmodule

FILE: hw/rtl/ctc_ctrl.sv
// ----------------------------------------------------------------------------
// ctc controller
// Sequences score intake, row decisions, division and result loads.
// ----------------------------------------------------------------------------
`include "ctc_greedy_decoder_macros.svh"

module ctc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic             i_s_axis_tlast,
    output logic             o_s_axis_tready,
    input  ctc_pkg::t_status i_status,
    output ctc_pkg::t_cmd    o_cmd
);

    ctc_pkg::t_state r_state;
    ctc_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ctc_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.acc = 1'b1;
                    if (i_s_axis_tlast) begin
                        n_state = ctc_pkg::S_ROW;
                    end
                end
            end
            ctc_pkg::S_ROW: begin
                o_cmd.row = 1'b1;
                if (i_status.emit_now) begin
                    n_state = ctc_pkg::S_CHAR;
                end else if (i_status.end_seq) begin
                    n_state = ctc_pkg::S_DSTART;
                end else begin
                    n_state = ctc_pkg::S_IDLE;
                end
            end
            ctc_pkg::S_CHAR: begin
                if (i_status.out_free) begin
                    o_cmd.load_char = 1'b1;
                    n_state = i_status.end_seq ? ctc_pkg::S_DSTART : ctc_pkg::S_IDLE;
                end
            end
            ctc_pkg::S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = ctc_pkg::S_DIV;
            end
            ctc_pkg::S_DIV: begin
                if (!i_status.div_busy) begin
                    n_state = ctc_pkg::S_END;
                end
            end
            ctc_pkg::S_END: begin
                if (i_status.out_free) begin
                    o_cmd.load_end = 1'b1;
                    n_state = ctc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ctc_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `CTC_ASSERT(a_load_needs_room, i_clk, i_rst_n, (o_cmd.load_char || o_cmd.load_end) |-> i_status.out_free)
    `CTC_ASSERT(a_div_runs, i_clk, i_rst_n, o_cmd.div_start |=> i_status.div_busy)
    `CTC_ASSERT(a_end_after_div, i_clk, i_rst_n, (r_state == ctc_pkg::S_END) |-> !i_status.div_busy)
    `CTC_ASSERT(a_row_follows_last, i_clk, i_rst_n, (o_cmd.acc && i_s_axis_tlast) |=> o_cmd.row)

endmodule

FILE: hw/rtl/ctc_greedy_decoder.sv
// ----------------------------------------------------------------------------
// ctc greedy decoder
// Streaming CTC greedy decoder: per-row argmax, blank and repeat removal,
// character results and a per-sequence average confidence.
// ----------------------------------------------------------------------------
// Scores are taken one per cycle while the decoder is idle. A score that ends
// a row (tlast) is followed by the row decision, plus the load of a character
// result when one is emitted (delayed while the output register is still held
// by the sink). A row that also ends the sequence (tuser) runs the restoring
// divider for the average: a start state, SCORE_WIDTH + clog2(MAX_STEPS)
// division steps (26 at the defaults), a wait until the divider finishes, and
// the load of the result. Such a row holds off the next score until its end
// result is loaded, which waits while the sink holds the output register.
// Results sit in a single output register; new scores are taken while a
// result waits there. Scores at position MAX_CLASSES and beyond in a row do
// not take part in the maximum.
// ----------------------------------------------------------------------------
module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = 4096,
    parameter int MAX_STEPS   = 1024,
    parameter int SCORE_WIDTH = 16,
    localparam int CLASS_W = $clog2(MAX_CLASSES),
    localparam int CNT_W   = $clog2(MAX_STEPS + 1),
    localparam int SUM_W   = SCORE_WIDTH + $clog2(MAX_STEPS),
    localparam int IN_W    = ((SCORE_WIDTH + 7) / 8) * 8,
    localparam int OUT_W   = ((CLASS_W + SCORE_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // score stream
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [IN_W-1:0]             i_s_axis_tdata,   // score
    input  logic                        i_s_axis_tlast,   // last_class
    input  logic                        i_s_axis_tuser,   // last_step
    // result stream
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [OUT_W-1:0]            o_m_axis_tdata,   // class_index, confidence, char_total
    output logic                        o_m_axis_tlast,   // last
    output logic                        o_m_axis_tuser,   // kind
    // char_count register
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ctc_pkg::CHARS_W-1:0] i_cfg_data
);

    ctc_pkg::t_cmd    w_cmd;
    ctc_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    // control
    ctc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (w_status),
        .o_cmd           (w_cmd)
    );

    // datapath
    ctc_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .SCORE_WIDTH (SCORE_WIDTH),
        .CLASS_W     (CLASS_W),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .IN_W        (IN_W),
        .OUT_W       (OUT_W)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule
